// ===== src/atab_pkg.sv =====
// Shared types, constants and helpers for the ARGB tint and alpha blend block.
// No dependencies; every other file in src except atab_if refers to this package by scoped name.
package atab_pkg;

    localparam int unsigned PixelWidth = 32;
    localparam int unsigned ChanWidth  = 8;
    localparam int unsigned ProdWidth  = 16;
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned PtrWidth   = $clog2(QueueDepth);
    localparam int unsigned CountWidth = $clog2(QueueDepth + 1);

    localparam logic [PixelWidth-1:0] TintNone  = 32'hFFFF_FFFF;
    localparam logic [ChanWidth-1:0]  ChanFull  = 8'd255;
    localparam logic [ChanWidth-1:0]  ChanZero  = 8'd0;
    localparam logic [ProdWidth-1:0]  RoundHalf = 16'd127;

    typedef logic [ChanWidth-1:0] chan_t;

    // What the back end has to do with a beat.
    typedef enum logic [1:0] {
        KIND_SKIP  = 2'd0,   // tinted alpha is zero: keep destination
        KIND_COPY  = 2'd1,   // tinted alpha is full: write tinted source
        KIND_BLEND = 2'd2    // partial alpha: blend over destination
    } atab_kind_t;

    typedef struct packed {
        atab_kind_t             kind;
        chan_t                  a;
        chan_t                  r;
        chan_t                  g;
        chan_t                  b;
        logic [PixelWidth-1:0]  dst;
    } atab_entry_t;

    // Exact x/255 for 0 <= x <= 65279 (quotient fits in 8 bits) using add and shift.
    function automatic chan_t div255(input logic [ProdWidth-1:0] x);
        logic [ProdWidth:0] t;
        t = {1'b0, x} + {9'd0, x[ProdWidth-1:ChanWidth]} + 17'd1;
        return t[ProdWidth-1:ChanWidth];
    endfunction

    // Rounded product term x*y + 127, at most 65152.
    function automatic logic [ProdWidth-1:0] mul_rnd(input chan_t x, input chan_t y);
        return ProdWidth'(x * y) + RoundHalf;
    endfunction

endpackage

// ===== src/atab_if.sv =====
// Stream channel interfaces for the ARGB tint and alpha blend block.
// Depends on nothing; beats move when valid and ready are both high.
interface atab_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] source_pixel;
    logic [31:0] dest_pixel;

    modport source (output valid, output source_pixel, output dest_pixel, input ready);
    modport sink   (input valid, input source_pixel, input dest_pixel, output ready);
endinterface

interface atab_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] blended_pixel;
    logic        write_enable;

    modport source (output valid, output blended_pixel, output write_enable, input ready);
    modport sink   (input valid, input blended_pixel, input write_enable, output ready);
endinterface

// ===== src/atab_front.sv =====
// Front end: accepts input beats, applies the tint and classifies each pixel.
// Depends on atab_pkg and atab_if; pushes into the queue in atab_fifo.
module atab_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [atab_pkg::PixelWidth-1:0]  tint,
    atab_in_if.sink                          in_ch,
    input  logic [atab_pkg::CountWidth-1:0]  fifo_count,
    output logic                             push,
    output atab_pkg::atab_entry_t            push_data
);

    logic                                    p1_valid_reg;
    logic [atab_pkg::ProdWidth-1:0]          prod_reg [4];
    logic [atab_pkg::ProdWidth-1:0]          prod_next [4];
    logic [atab_pkg::PixelWidth-1:0]         dst_reg;
    logic [atab_pkg::CountWidth-1:0]         level;
    logic                                    accept;
    atab_pkg::chan_t                         tch [4];

    // Reserve a queue slot for every beat in flight so a push never finds it full.
    assign level       = fifo_count + atab_pkg::CountWidth'(p1_valid_reg);
    assign in_ch.ready = (level < atab_pkg::CountWidth'(atab_pkg::QueueDepth));
    assign accept      = in_ch.valid && in_ch.ready;

    // Lane i covers byte i; a tint byte of 255 maps x to x exactly, so no bypass.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_next[i] = atab_pkg::mul_rnd(in_ch.source_pixel[8*i +: 8], tint[8*i +: 8]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            dst_reg <= in_ch.dest_pixel;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            tch[i] = atab_pkg::div255(prod_reg[i]);
        end
        push_data.a   = tch[3];
        push_data.r   = tch[2];
        push_data.g   = tch[1];
        push_data.b   = tch[0];
        push_data.dst = dst_reg;
        if (tch[3] == atab_pkg::ChanZero)
        begin
            push_data.kind = atab_pkg::KIND_SKIP;
        end
        else if (tch[3] == atab_pkg::ChanFull)
        begin
            push_data.kind = atab_pkg::KIND_COPY;
        end
        else
        begin
            push_data.kind = atab_pkg::KIND_BLEND;
        end
    end

    assign push = p1_valid_reg;

endmodule

// ===== src/atab_fifo.sv =====
// Short queue of classified pixels between the front and back ends.
// Depends on atab_pkg for the entry type and depth.
module atab_fifo (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  atab_pkg::atab_entry_t            push_data,
    input  logic                             pop,
    output atab_pkg::atab_entry_t            head,
    output logic                             empty,
    output logic [atab_pkg::CountWidth-1:0]  count
);

    atab_pkg::atab_entry_t                   mem_reg [atab_pkg::QueueDepth];
    logic [atab_pkg::PtrWidth-1:0]           wr_ptr_reg;
    logic [atab_pkg::PtrWidth-1:0]           rd_ptr_reg;
    logic [atab_pkg::CountWidth-1:0]         count_reg;
    logic [atab_pkg::CountWidth-1:0]         count_next;

    assign empty = (count_reg == '0);
    assign count = count_reg;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + atab_pkg::CountWidth'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - atab_pkg::CountWidth'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + atab_pkg::PtrWidth'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + atab_pkg::PtrWidth'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < atab_pkg::CountWidth'(atab_pkg::QueueDepth))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= atab_pkg::CountWidth'(atab_pkg::QueueDepth))
        else $error("queue count beyond depth");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 || count_reg == atab_pkg::CountWidth'(atab_pkg::QueueDepth) ||
        wr_ptr_reg != rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

// ===== src/atab_back.sv =====
// Back end: blends classified pixels over the destination and holds the result.
// Depends on atab_pkg and atab_if; pops from atab_fifo.
module atab_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  atab_pkg::atab_entry_t   head,
    input  logic                    empty,
    output logic                    pop,
    atab_out_if.source              out_ch
);

    logic                                    b1_valid_reg;
    atab_pkg::atab_entry_t                   b1_ent_reg;
    logic [atab_pkg::ProdWidth-1:0]          b1_prod_reg [4];
    logic [atab_pkg::ProdWidth-1:0]          b1_prod_next [4];
    logic                                    b2_valid_reg;
    logic [atab_pkg::PixelWidth-1:0]         b2_pix_reg;
    logic [atab_pkg::PixelWidth-1:0]         b2_pix_next;
    logic                                    b2_we_reg;
    logic                                    b2_we_next;
    logic                                    b1_adv;
    logic                                    b2_adv;
    atab_pkg::chan_t                         inv;

    assign b2_adv = !b2_valid_reg || out_ch.ready;
    assign b1_adv = !b1_valid_reg || b2_adv;
    assign pop    = !empty && b1_adv;

    // Stage 1: channel products; lane 3 is the destination alpha term.
    always_comb
    begin
        inv = ~head.a;
        b1_prod_next[2] = atab_pkg::mul_rnd(head.r, head.a) + 16'(head.dst[23:16] * inv);
        b1_prod_next[1] = atab_pkg::mul_rnd(head.g, head.a) + 16'(head.dst[15:8] * inv);
        b1_prod_next[0] = atab_pkg::mul_rnd(head.b, head.a) + 16'(head.dst[7:0] * inv);
        b1_prod_next[3] = atab_pkg::mul_rnd(head.dst[31:24], inv);
    end

    // Stage 2: scale by 1/255 and pick the result for the pixel's kind.
    always_comb
    begin
        case (b1_ent_reg.kind)
            atab_pkg::KIND_COPY:
            begin
                b2_pix_next = {b1_ent_reg.a, b1_ent_reg.r, b1_ent_reg.g, b1_ent_reg.b};
                b2_we_next  = 1'b1;
            end
            atab_pkg::KIND_BLEND:
            begin
                b2_pix_next = {b1_ent_reg.a + atab_pkg::div255(b1_prod_reg[3]),
                               atab_pkg::div255(b1_prod_reg[2]),
                               atab_pkg::div255(b1_prod_reg[1]),
                               atab_pkg::div255(b1_prod_reg[0])};
                b2_we_next  = 1'b1;
            end
            default:
            begin
                b2_pix_next = b1_ent_reg.dst;
                b2_we_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
        end
        else
        begin
            if (b1_adv)
            begin
                b1_valid_reg <= pop;
            end
            if (b2_adv)
            begin
                b2_valid_reg <= b1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_ent_reg <= head;
            for (int i = 0; i < 4; i++)
            begin
                b1_prod_reg[i] <= b1_prod_next[i];
            end
        end
        if (b2_adv && b1_valid_reg)
        begin
            b2_pix_reg <= b2_pix_next;
            b2_we_reg  <= b2_we_next;
        end
    end

    assign out_ch.valid         = b2_valid_reg;
    assign out_ch.blended_pixel = b2_pix_reg;
    assign out_ch.write_enable  = b2_we_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        b2_valid_reg && !out_ch.ready |=> b2_valid_reg && $stable(b2_pix_reg))
        else $error("result changed while stalled");

    a_b1_kept: assert property (@(posedge clk) disable iff (!rst_n)
        b1_valid_reg && !b2_adv |=> b1_valid_reg && $stable(b1_ent_reg))
        else $error("blend stage lost a beat under stall");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !b1_valid_reg || b2_adv)
        else $error("pop into an occupied stage");

endmodule

// ===== src/argb_tint_alpha_blend.sv =====
// Top level of the ARGB8888 tint and source-over alpha blend block.
// Depends on atab_pkg, atab_if, atab_front, atab_fifo and atab_back.
//
// Usage:
//   in_ch  (atab_in_if.sink) takes one beat per pixel: source_pixel and the
//          dest_pixel it lands on, both ARGB8888 with alpha in bits 31:24.
//   out_ch (atab_out_if.source) gives one beat per input beat, in order:
//          blended_pixel and write_enable (low when the tinted alpha is zero;
//          blended_pixel then carries dest_pixel unchanged).
//   cfg_we / cfg_wdata write the tint register; all ones disables tinting.
//          Write it only while no beat is in flight.
// Throughput: one pixel per clock cycle, sustained, when out_ch is ready.
// Path: an accepted beat passes the tint product register (loaded on the
//   accepting edge), then a queue slot, the blend product register and the
//   output register, which drives out_ch.valid.
// A four-entry queue between the tint front end and the blend back end lets
//   each side stall independently; in_ch.ready drops only when the queue plus
//   the beat in the tint stage fill its four slots.
// Reset: clears every valid flag and the queue, and loads the tint register
//   with all ones. When out_ch stalls, the result is held steady and the blend
//   stage plus the queue absorb up to five further beats before in_ch.ready falls.
module argb_tint_alpha_blend (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [atab_pkg::PixelWidth-1:0]  cfg_wdata,
    atab_in_if.sink                          in_ch,
    atab_out_if.source                       out_ch
);

    logic [atab_pkg::PixelWidth-1:0]         tint_reg;
    logic                                    push;
    atab_pkg::atab_entry_t                   push_data;
    logic                                    pop;
    atab_pkg::atab_entry_t                   head;
    logic                                    empty;
    logic [atab_pkg::CountWidth-1:0]         fifo_count;

    // Hold tint; user makes writes land only while pipeline is idle, unchecked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tint_reg <= atab_pkg::TintNone;
        end
        else if (cfg_we)
        begin
            tint_reg <= cfg_wdata;
        end
    end

    // Tint and classify each accepted beat.
    atab_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tint       (tint_reg),
        .in_ch      (in_ch),
        .fifo_count (fifo_count),
        .push       (push),
        .push_data  (push_data)
    );

    // Decouple the front end from output stalls.
    atab_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .count     (fifo_count)
    );

    // Blend over the destination and drive the result beat.
    atab_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .out_ch (out_ch)
    );

    a_skip_keeps_dest_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_data.kind == atab_pkg::KIND_SKIP |-> push_data.a == atab_pkg::ChanZero)
        else $error("skip beat with nonzero alpha");

    a_copy_full_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_data.kind == atab_pkg::KIND_COPY |-> push_data.a == atab_pkg::ChanFull)
        else $error("copy beat without full alpha");

    a_no_tint_identity: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && tint_reg == atab_pkg::TintNone
        |=> push && push_data.a == $past(in_ch.source_pixel[31:24]))
        else $error("untinted alpha altered");

endmodule

// ===== dv/tb_argb_tint_alpha_blend.sv =====
// Testbench for argb_tint_alpha_blend: directed table, then random phases.
// Depends on src/atab_pkg.sv, src/atab_if.sv and src/argb_tint_alpha_blend.sv.
module tb_argb_tint_alpha_blend;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ClkHalf     = 10;
    localparam int unsigned ResetCycles = 8;
    localparam int unsigned IdlePercent = 27;
    // Idle time to let the block settle after the last result is back.
    localparam int unsigned DrainCycles = 8;
    localparam int unsigned NumPhases   = 10;
    localparam int unsigned PhaseBeats  = 200;
    localparam int unsigned RoundBias   = 127;
    localparam int unsigned ChanMax     = 255;
    localparam int unsigned NumDirRows  = 20;

    typedef logic [atab_pkg::PixelWidth-1:0] pixel_t;

    // One predicted output beat.
    typedef struct {
        pixel_t pixel;
        logic   written;
    } blend_result_t;

    // One row of the directed table. Rows with known set carry their result;
    // the others go through the predictor.
    typedef struct {
        pixel_t tint;
        pixel_t src;
        pixel_t dst;
        bit     known;
        pixel_t pixel;
        logic   written;
    } stim_row_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   cfg_we;
    pixel_t cfg_wdata;

    atab_in_if  in_bus ();
    atab_out_if out_bus ();

    argb_tint_alpha_blend i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_bus),
        .out_ch    (out_bus)
    );

    always #(ClkHalf) clk = ~clk;

    // Predictor state: the tint register as the block should hold it.
    pixel_t        tint_reg = atab_pkg::TintNone;
    // Results still owed by the block, oldest first.
    blend_result_t pending_q [$];
    int            mismatches = 0;
    // When set, neither side idles: runs the block at full rate.
    bit            free_run   = 1'b0;

    // Directed rows: transparent and opaque sources, alpha one step off
    // either extreme, zero tint, full-alpha tint with black color, a tint
    // that is one bit off no-tint, and a tint that rounds alpha down to zero.
    stim_row_t dir_rows [NumDirRows] = '{
        '{32'hFFFF_FFFF, 32'h0012_3456, 32'hA1B2_C3D4, 1'b1, 32'hA1B2_C3D4, 1'b0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{32'hFFFF_FFFF, 32'hFF11_2233, 32'h0000_0000, 1'b1, 32'hFF11_2233, 1'b1},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1},
        '{32'hFFFF_FFFF, 32'h80FF_0000, 32'hFF00_00FF, 1'b0, 32'h0, 1'b0},
        '{32'hFFFF_FFFF, 32'h01FF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{32'hFFFF_FFFF, 32'hFE00_0000, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{32'hFFFF_FFFF, 32'h7F80_8080, 32'h7F80_8080, 1'b0, 32'h0, 1'b0},
        '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 32'h1234_5678, 1'b0},
        '{32'h0000_0000, 32'h80AB_CDEF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{32'hFF00_0000, 32'hFFAB_CDEF, 32'h0000_0000, 1'b1, 32'hFF00_0000, 1'b1},
        '{32'hFF00_0000, 32'h40AB_CDEF, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{32'h80FF_FFFF, 32'hFF10_2030, 32'h0000_FF00, 1'b0, 32'h0, 1'b0},
        '{32'h01FF_FFFF, 32'h7FFF_FFFF, 32'h0F0F_0F0F, 1'b1, 32'h0F0F_0F0F, 1'b0},
        '{32'h01FF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFE, 1'b1},
        '{32'hFFFF_FFFE, 32'h8080_8080, 32'h8080_8080, 1'b0, 32'h0, 1'b0},
        '{32'h5A3C_96C8, 32'hC0F0_1E64, 32'h3366_CC99, 1'b0, 32'h0, 1'b0},
        '{32'h5A3C_96C8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0}
    };

    // Scale one channel by a tint byte, rounded to nearest.
    function automatic int unsigned tint_chan(input int unsigned x, input int unsigned t);
        return (x * t + RoundBias) / ChanMax;
    endfunction

    // Source-over mix of one color channel at source alpha a.
    function automatic int unsigned mix_chan(input int unsigned s, input int unsigned d,
                                             input int unsigned a);
        return (s * a + d * (ChanMax - a) + RoundBias) / ChanMax;
    endfunction

    // Predict the output beat for one pixel pair under the given tint.
    function automatic blend_result_t compose_pixel(input pixel_t tint, input pixel_t src,
                                                    input pixel_t dst);
        blend_result_t res;
        int unsigned   sa, sr, sg, sb, da;
        sa = src[31:24];
        sr = src[23:16];
        sg = src[15:8];
        sb = src[7:0];
        da = dst[31:24];
        if (tint != atab_pkg::TintNone) begin
            sa = tint_chan(sa, tint[31:24]);
            sr = tint_chan(sr, tint[23:16]);
            sg = tint_chan(sg, tint[15:8]);
            sb = tint_chan(sb, tint[7:0]);
        end
        if (sa == 0) begin
            // Fully transparent after tint: destination passes through unwritten.
            res.pixel   = dst;
            res.written = 1'b0;
        end else if (sa == ChanMax) begin
            // Opaque: destination is not read at all.
            res.pixel   = {sa[7:0], sr[7:0], sg[7:0], sb[7:0]};
            res.written = 1'b1;
        end else begin
            res.pixel[31:24] = 8'(sa + (da * (ChanMax - sa) + RoundBias) / ChanMax);
            res.pixel[23:16] = 8'(mix_chan(sr, dst[23:16], sa));
            res.pixel[15:8]  = 8'(mix_chan(sg, dst[15:8], sa));
            res.pixel[7:0]   = 8'(mix_chan(sb, dst[7:0], sa));
            res.written      = 1'b1;
        end
        return res;
    endfunction

    // Bias source alpha toward zero, full, and one step inside each.
    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd1;
            3:       return 8'd254;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic pixel_t pick_tint();
        case ($urandom_range(4))
            0:       return atab_pkg::TintNone;
            1:       return 32'h0000_0000;
            2:       return 32'hFFFF_FFFE;
            3:       return {8'hFF, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Drive one beat, idling at random first; log the prediction on accept.
    task automatic send_pixel(input pixel_t src, input pixel_t dst, input blend_result_t res);
        while (!free_run && $urandom_range(99) < IdlePercent) begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid        <= 1'b1;
        in_bus.source_pixel <= src;
        in_bus.dest_pixel   <= dst;
        // ready is read before this edge's updates land, so it is the
        // value the block saw when it took the beat.
        do
            @(posedge clk);
        while (!in_bus.ready);
        pending_q.push_back(res);
    endtask

    // Drop valid, let the pipe empty, then write the tint register.
    task automatic program_tint(input pixel_t value);
        in_bus.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tint_reg = value;
    endtask

    // Output side: check every accepted beat against the oldest prediction,
    // and stall at random unless running free.
    always @(posedge clk) begin
        blend_result_t want;
        if (rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected beat: blended_pixel %h write_enable %b",
                       out_bus.blended_pixel, out_bus.write_enable);
                mismatches++;
            end else begin
                want = pending_q.pop_front();
                if (out_bus.blended_pixel !== want.pixel) begin
                    $error("blended_pixel: expected %h, got %h",
                           want.pixel, out_bus.blended_pixel);
                    mismatches++;
                end
                if (out_bus.write_enable !== want.written) begin
                    $error("write_enable: expected %b, got %b",
                           want.written, out_bus.write_enable);
                    mismatches++;
                end
            end
        end
        out_bus.ready <= free_run || ($urandom_range(99) >= IdlePercent);
    end

    // Stimulus: reset, directed table, random phases, drain, verdict.
    initial begin
        blend_result_t res;
        pixel_t        src, dst;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        in_bus.valid        = 1'b0;
        in_bus.source_pixel = '0;
        in_bus.dest_pixel   = '0;
        out_bus.ready       = 1'b0;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: reprogram the tint whenever the table moves to a new one.
        foreach (dir_rows[i]) begin
            if (dir_rows[i].tint != tint_reg)
                program_tint(dir_rows[i].tint);
            if (dir_rows[i].known) begin
                res.pixel   = dir_rows[i].pixel;
                res.written = dir_rows[i].written;
            end else begin
                res = compose_pixel(tint_reg, dir_rows[i].src, dir_rows[i].dst);
            end
            send_pixel(dir_rows[i].src, dir_rows[i].dst, res);
        end

        // Random part: one tint per phase, no-tint and zero tint first.
        // One phase runs with both sides always ready.
        for (int p = 0; p < NumPhases; p++) begin
            if (p == 0)
                program_tint(atab_pkg::TintNone);
            else if (p == 1)
                program_tint(32'h0000_0000);
            else
                program_tint(pick_tint());
            free_run = (p == 4);
            for (int n = 0; n < PhaseBeats; n++) begin
                src = {pick_alpha(), 24'($urandom)};
                dst = $urandom;
                res = compose_pixel(tint_reg, src, dst);
                send_pixel(src, dst, res);
            end
        end
        free_run = 1'b0;

        // Drain: hold valid low until every result is back, then settle.
        in_bus.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
